/* sv/npcs_pkg.sv */
// shared types and constants for the nearest palette colour search core
// no dependencies; imported by nearest_palette_color_search_core and npcs_dist
package npcs_pkg;

	localparam int PALETTE_ENTRIES = 256;
	localparam int IDX_W   = $clog2(PALETTE_ENTRIES);
	localparam int CNT_W   = $clog2(PALETTE_ENTRIES + 1);
	localparam int SIZE_W  = 9;
	localparam int CHAN_W  = 8;
	localparam int COLOR_W = 3 * CHAN_W;
	localparam int SQ_W    = 2 * CHAN_W;
	// three squares of at most 255*255 each stay below 262144
	localparam int DIST_W  = 18;

	localparam logic [CHAN_W-1:0] QUANT_MASK = 8'hFC;
	localparam logic [DIST_W-1:0] DIST_MAX   = '1;

	typedef enum logic {
		OP_QUERY = 1'b0,
		OP_WRITE = 1'b1
	} op_t;

	// tag that travels with an entry through the read and distance stages
	typedef struct packed {
		logic             vld;
		logic [IDX_W-1:0] idx;
	} tag_t;

endpackage

/* sv/nearest_palette_color_search_core.sv */
// nearest palette colour search core: palette ram, scan sequencer, best-match tracking
// depends on npcs_pkg, npcs_ram, npcs_dist
//
// usage
//   s_axis carries one word per item: tuser = operation (0 query, 1 palette write),
//   tdata = entry_index, red, green, blue from the lowest byte up.
//   a palette write gives no result word and leaves the block idle.
//   a query returns one m_axis word: tuser = found, tdata = nearest_index.
//   cfg_data sets palette_size (values above 256 act as 256); write it while idle.
// timing
//   a query scans the first palette_size entries through one distance unit,
//   one entry per cycle: the ram read, the distance stage and the compare form
//   a three deep pipe, which drains before the result word is loaded; a query
//   on an empty palette goes straight to its result.
//   s_axis_tready is low from a query's acceptance until its result word is loaded.
// reset
//   arst_n clears the sequencer, the output valid and palette_size; the palette
//   ram is not cleared and must be written before it is searched.
// stalls
//   a finished result is held in the output register until taken; the next item
//   is accepted meanwhile, and a second query waits at its end for the register.
module nearest_palette_color_search_core
	import npcs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // entry_index, red, green, blue
	input  logic        s_axis_tuser,  // operation
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // nearest_index
	output logic        m_axis_tuser,  // found
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [SIZE_W-1:0] cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	state_t             state_q;
	logic [SIZE_W-1:0]  size_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [IDX_W-1:0]   addr_q;
	logic [COLOR_W-1:0] query_q;
	logic [DIST_W-1:0]  best_dist_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic               found_q;
	logic               m_valid_q;
	logic [7:0]         m_index_q;
	logic               m_found_q;
	tag_t               tag_s1;

	logic               in_acc;
	op_t                op;
	logic [7:0]         entry_index;
	logic [COLOR_W-1:0] in_color;
	logic [COLOR_W-1:0] in_quant;
	logic [CNT_W-1:0]   size_sat;
	logic               ram_we;
	logic               ram_re;
	logic [COLOR_W-1:0] ram_rdata;
	logic [DIST_W-1:0]  dist_s2;
	tag_t               tag_s2;
	logic               scan_last;
	logic               out_free;

	assign op          = op_t'(s_axis_tuser);
	assign entry_index = s_axis_tdata[7:0];
	// store layout: red high, blue low
	assign in_color    = {s_axis_tdata[15:8], s_axis_tdata[23:16], s_axis_tdata[31:24]};
	assign in_quant    = in_color & {QUANT_MASK, QUANT_MASK, QUANT_MASK};

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	assign size_sat  = (int'(size_q) > PALETTE_ENTRIES) ? CNT_W'(PALETTE_ENTRIES)
	                                                    : CNT_W'(size_q);
	assign ram_we    = in_acc && (op == OP_WRITE) && (int'(entry_index) < PALETTE_ENTRIES);
	assign ram_re    = (state_q == ST_SCAN);
	assign scan_last = (CNT_W'(addr_q) + CNT_W'(1)) == cnt_q;
	assign out_free  = !m_valid_q || m_axis_tready;

	npcs_ram #(
		.WIDTH (COLOR_W),
		.DEPTH (PALETTE_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (entry_index[IDX_W-1:0]),
		.wdata (in_color),
		.re    (ram_re),
		.raddr (addr_q),
		.rdata (ram_rdata)
	);

	npcs_dist u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.entry   (ram_rdata),
		.query   (query_q),
		.tag_s1  (tag_s1),
		.dist_s2 (dist_s2),
		.tag_s2  (tag_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			size_q <= cfg_data;
		end
	end

	// read tag is registered like the ram read data and stays in step with it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1.vld <= ram_re;
			tag_s1.idx <= addr_q;
		end
	end

	// strict less-than keeps the lowest index on ties, entries arrive in order
	always_ff @(posedge clk) begin
		if (in_acc) begin
			best_dist_q <= DIST_MAX;
			best_idx_q  <= '0;
			query_q     <= in_quant;
			cnt_q       <= size_sat;
			found_q     <= (size_sat != '0);
		end else if (tag_s2.vld && (dist_s2 < best_dist_q)) begin
			best_dist_q <= dist_s2;
			best_idx_q  <= tag_s2.idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			addr_q    <= '0;
			m_valid_q <= 1'b0;
			m_index_q <= '0;
			m_found_q <= 1'b0;
		end else begin
			if (m_valid_q && m_axis_tready && (state_q != ST_DONE)) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					addr_q <= '0;
					if (in_acc && (op == OP_QUERY)) begin
						state_q <= (size_sat == '0) ? ST_DONE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					addr_q <= addr_q + 1'b1;
					if (scan_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!tag_s1.vld && !tag_s2.vld) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						m_found_q <= found_q;
						m_index_q <= found_q ? 8'(best_idx_q) : 8'd0;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_index_q;
	assign m_axis_tuser  = m_found_q;

	// no entry may still be in flight once the block takes a new word
	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> (!tag_s1.vld && !tag_s2.vld))
		else $error("scan pipe not empty while idle");

	// the scan never reads past the palette size in use
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (CNT_W'(addr_q) < cnt_q))
		else $error("scan address beyond palette size");

	// a new result word only comes out of the done state
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result word without finished search");

	// an empty palette answer carries index zero
	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && !m_found_q) |-> (m_index_q == 8'd0))
		else $error("index set on empty palette answer");

endmodule

/* sv/npcs_ram.sv */
// generic single write port, single read port ram with registered read data
// no dependencies
module npcs_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* sv/npcs_dist.sv */
// distance stage: registered sum of squared channel differences of one palette entry against the query
// depends on npcs_pkg
module npcs_dist
	import npcs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic [COLOR_W-1:0] entry,
	input  logic [COLOR_W-1:0] query,
	input  tag_t               tag_s1,
	output logic [DIST_W-1:0]  dist_s2,
	output tag_t               tag_s2
);

	logic [CHAN_W-1:0] diff [3];
	logic [SQ_W-1:0]   sq   [3];
	logic [DIST_W-1:0] sum;
	logic [DIST_W-1:0] dist_s2_r;
	tag_t              tag_s2_r;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			if (entry[c*CHAN_W +: CHAN_W] > query[c*CHAN_W +: CHAN_W]) begin
				diff[c] = entry[c*CHAN_W +: CHAN_W] - query[c*CHAN_W +: CHAN_W];
			end else begin
				diff[c] = query[c*CHAN_W +: CHAN_W] - entry[c*CHAN_W +: CHAN_W];
			end
			sq[c] = diff[c] * diff[c];
		end
		sum = DIST_W'(sq[0]) + DIST_W'(sq[1]) + DIST_W'(sq[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2_r  <= '0;
			dist_s2_r <= '0;
		end else begin
			tag_s2_r  <= tag_s1;
			dist_s2_r <= sum;
		end
	end

	assign dist_s2 = dist_s2_r;
	assign tag_s2  = tag_s2_r;

endmodule
